// ===== src/u8d_pkg.sv =====
package u8d_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned POS_W  = 2;

  // lead byte classes
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;
  localparam logic [LEN_W-1:0] LEN_1   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3   = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4   = 3'd4;

  // one decode job: the bytes to work through, lead first, and how many
  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]       count;
    logic                   text_end;
  } u8d_entry_t;

  function automatic logic [LEN_W-1:0] seq_len(input logic [BYTE_W-1:0] lead);
    logic [LEN_W-1:0] len;
    if ((lead & ASCII_MASK) == 8'h00) begin
      len = LEN_1;
    end else if ((lead & LEAD2_MASK) == LEAD2_CODE) begin
      len = LEN_2;
    end else if ((lead & LEAD3_MASK) == LEAD3_CODE) begin
      len = LEN_3;
    end else if ((lead & LEAD4_MASK) == LEAD4_CODE) begin
      len = LEN_4;
    end else begin
      len = LEN_BAD;
    end
    return len;
  endfunction

endpackage

// ===== src/u8d_front.sv =====
module u8d_front import u8d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_end,
  output logic              push_valid,
  input  logic              push_ready,
  output u8d_entry_t        push_entry
);

  logic [1:0]              held_count;
  logic [1:0]              held_count_next;
  logic [2:0][BYTE_W-1:0]  held_bytes;
  logic [3:0][BYTE_W-1:0]  held_pad;

  logic [CNT_W-1:0] total;
  logic [BYTE_W-1:0] lead;
  logic [LEN_W-1:0]  lead_len;
  logic              complete;
  logic              produce;
  logic              accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  assign total    = {1'b0, held_count} + CNT_W'(1);
  assign lead     = (held_count == 2'd0) ? in_byte : held_bytes[0];
  assign lead_len = seq_len(lead);
  assign complete = (lead_len != LEN_BAD) && (total == lead_len);
  // a job goes out on a finished sequence, a bad lead or the end of text
  assign produce  = in_end || (lead_len == LEN_BAD) || complete;

  assign held_pad = {{BYTE_W{1'b0}}, held_bytes};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < int'(held_count)) begin
        push_entry.bytes[i] = held_pad[i];
      end else if (i == int'(held_count)) begin
        push_entry.bytes[i] = in_byte;
      end else begin
        push_entry.bytes[i] = '0;
      end
    end
    push_entry.count    = total;
    push_entry.text_end = in_end;
  end

  assign push_valid = accept && produce;

  always_comb begin
    held_count_next = held_count;
    if (accept) begin
      held_count_next = produce ? 2'd0 : held_count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !produce) begin
      for (int i = 0; i < 3; i++) begin
        if (i == int'(held_count)) begin
          held_bytes[i] <= in_byte;
        end
      end
    end
  end

  // held bytes always form a strict prefix of one sequence
  a_held_prefix: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd0 |-> ({1'b0, held_count} < seq_len(held_bytes[0])))
    else $error("held bytes are not an incomplete prefix");

endmodule

// ===== src/u8d_queue.sv =====
module u8d_queue import u8d_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  u8d_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop_ready,
  output u8d_entry_t pop_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  u8d_entry_t         slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != FILL_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("queue fill beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) || (fill == FILL_W'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with fill");

endmodule

// ===== src/u8d_back.sv =====
module u8d_back import u8d_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  u8d_entry_t      job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_cp,
  output logic            out_done
);

  logic [POS_W-1:0]       pos;
  logic [POS_W-1:0]       pos_next;
  logic [31:0]            window;
  logic [BYTE_W-1:0]      w0, w1, w2, w3;
  logic [LEN_W-1:0]       len;
  logic [CNT_W-1:0]       remaining;
  logic                   whole;
  logic [CNT_W-1:0]       step;
  logic                   last;
  logic                   advance;
  logic [CP_W-1:0]        cp;

  assign window    = job.bytes >> {pos, 3'b000};
  assign w0        = window[7:0];
  assign w1        = window[15:8];
  assign w2        = window[23:16];
  assign w3        = window[31:24];
  assign len       = seq_len(w0);
  assign remaining = job.count - {1'b0, pos};
  assign whole     = (len != LEN_BAD) && (len <= remaining);
  // bad lead or truncated tail: one byte consumed, code point zero
  assign step      = whole ? len : CNT_W'(1);
  assign last      = (({1'b0, pos} + step) == job.count);

  always_comb begin
    cp = '0;
    if (whole) begin
      case (len)
        LEN_1:   cp = {13'd0, w0};
        LEN_2:   cp = {10'd0, w0[4:0], w1[5:0]};
        LEN_3:   cp = {5'd0, w0[3:0], w1[5:0], w2[5:0]};
        LEN_4:   cp = {w0[2:0], w1[5:0], w2[5:0], w3[5:0]};
        default: cp = '0;
      endcase
    end
  end

  assign advance   = job_valid && (!out_valid || out_ready);
  assign job_ready = advance && last;

  always_comb begin
    pos_next = pos;
    if (advance) begin
      pos_next = last ? '0 : pos + step[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      pos <= pos_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cp   <= cp;
      out_done <= job.text_end && last;
    end
  end

  a_pos_inside: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> ({1'b0, pos} < job.count))
    else $error("decode position past end of job");

  a_pos_idle: assert property (@(posedge clk) disable iff (rst)
    !job_valid |-> pos == '0)
    else $error("decode position left over without a job");

endmodule

// ===== src/utf8_byte_stream_decoder_core.sv =====
// utf8 byte stream decoder
//
// input stream: one byte of utf-8 text per transfer on s_tdata[7:0], with
// s_tlast marking the final byte of a text. output stream: one code point per
// transfer on m_tdata[20:0], with m_tlast on the last code point caused by the
// final byte.
// throughput: one byte per cycle while the queue has room. a byte gives at most
// one code point unless it ends a text inside an unfinished sequence; then up to
// three code points leave, one per cycle while m_tready is high, set by the single
// decode unit in the back end. a code point reaches m_tvalid through the queue,
// written at the transfer of the byte that completes it, and then the output
// register, loaded when the back end takes that code point.
// reset clears the held partial sequence, the queue and the output valid flag.
// when the receiver stalls, the output register holds its code point, the
// back end stops, the queue fills and s_tready drops once the queue is full.
module utf8_byte_stream_decoder_core import u8d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT  // 2 .. 16 jobs
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic        m_tlast    // text_done
);

  // front end to queue
  logic       push_valid;
  logic       push_ready;
  u8d_entry_t push_entry;

  // queue to back end
  logic       job_valid;
  logic       job_ready;
  u8d_entry_t job;

  logic [CP_W-1:0] code_point;

  // front end gathers bytes of a sequence and hands out whole decode jobs
  u8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_end     (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // short job queue decouples byte intake from code point output
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_entry  (job)
  );

  // back end walks a job and emits one code point per cycle while the output is not stalled
  u8d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_cp    (code_point),
    .out_done  (m_tlast)
  );

  assign m_tdata = {3'b000, code_point};

  // a job is only ever queued on an accepted byte
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> s_tvalid && s_tready)
    else $error("job queued without a byte transfer");

endmodule

// ===== tb/tb_utf8_byte_stream_decoder_core.sv =====
`timescale 1ns / 100ps

module tb_utf8_byte_stream_decoder_core;
  import u8d_pkg::*;

  localparam int PREDICT      = -1;  // row is checked against the predictor
  localparam int RANDOM_BYTES = 308;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE       = 10;

  typedef struct {
    logic [20:0] cp;
    logic        done;
  } code_point_t;

  typedef struct {
    logic [7:0]  data;
    logic        eot;
    int          n_fix;
    logic [20:0] cp0;
    logic [20:0] cp1;
    logic [20:0] cp2;
    logic [2:0]  done;  // bit i is text_done of result i
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;

  // decoder state kept by the predictor
  logic [7:0]  held [3];
  int          held_n = 0;

  code_point_t step_out [$];
  code_point_t cp_pending [$];
  int          errors = 0;
  int          random_bytes = 0;
  int          tx_idle_max = 5;
  int          rx_idle_max = 5;
  int          hold_cycles = 0;

  //   data  eot   n        cp0        cp1    cp2    done
  dir_row_t dir_rows [22] = '{
    '{8'h00, 1'b0, 1,       21'h0,     21'h0, 21'h0, 3'b000},  // lowest ascii
    '{8'h7F, 1'b1, 1,       21'h7F,    21'h0, 21'h0, 3'b001},  // highest ascii, ends text
    '{8'hFF, 1'b0, 1,       21'h0,     21'h0, 21'h0, 3'b000},  // bad lead, all ones
    '{8'hF8, 1'b0, 1,       21'h0,     21'h0, 21'h0, 3'b000},  // bad lead 11111xxx
    '{8'h80, 1'b1, 1,       21'h0,     21'h0, 21'h0, 3'b001},  // stray continuation at end
    '{8'hC2, 1'b0, 0,       21'h0,     21'h0, 21'h0, 3'b000},  // two-byte lead held
    '{8'hA9, 1'b0, 1,       21'hA9,    21'h0, 21'h0, 3'b000},
    '{8'hDF, 1'b0, PREDICT, 21'h0,     21'h0, 21'h0, 3'b000},  // top of two-byte range
    '{8'hBF, 1'b0, PREDICT, 21'h0,     21'h0, 21'h0, 3'b000},
    '{8'hE2, 1'b0, PREDICT, 21'h0,     21'h0, 21'h0, 3'b000},  // three-byte sequence
    '{8'h82, 1'b0, PREDICT, 21'h0,     21'h0, 21'h0, 3'b000},
    '{8'hAC, 1'b0, PREDICT, 21'h0,     21'h0, 21'h0, 3'b000},
    '{8'hF7, 1'b0, PREDICT, 21'h0,     21'h0, 21'h0, 3'b000},  // largest four-byte value
    '{8'hBF, 1'b0, PREDICT, 21'h0,     21'h0, 21'h0, 3'b000},
    '{8'hBF, 1'b0, PREDICT, 21'h0,     21'h0, 21'h0, 3'b000},
    '{8'hBF, 1'b0, 1,       21'h1FFFFF, 21'h0, 21'h0, 3'b000},
    '{8'hF0, 1'b0, 0,       21'h0,     21'h0, 21'h0, 3'b000},  // truncated at end:
    '{8'h41, 1'b0, 0,       21'h0,     21'h0, 21'h0, 3'b000},  // lead gives zero, rest
    '{8'hC3, 1'b1, 3,       21'h0,     21'h41, 21'h0, 3'b100}, // decoded again
    '{8'hE0, 1'b1, 1,       21'h0,     21'h0, 21'h0, 3'b001},  // lone lead at end
    '{8'hC3, 1'b0, PREDICT, 21'h0,     21'h0, 21'h0, 3'b000},  // follower not checked
    '{8'h29, 1'b1, PREDICT, 21'h0,     21'h0, 21'h0, 3'b000}
  };

  utf8_byte_stream_decoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // works out the code points one byte causes and updates the held bytes
  task automatic utf8_decode_step(input logic [7:0] data, input logic eot);
    logic [7:0]  seq [4];
    logic [20:0] cp;
    int          k;
    int          p;
    int          len;
    bit          stop;
    step_out.delete();
    k = held_n;
    for (int i = 0; i < k; i++) seq[i] = held[i];
    seq[k] = data;
    k++;
    p = 0;
    stop = 1'b0;
    while (p < k && !stop) begin
      casez (seq[p])
        8'b0???????: len = 1;
        8'b110?????: len = 2;
        8'b1110????: len = 3;
        8'b11110???: len = 4;
        default:     len = 0;
      endcase
      if (len == 0) begin
        cp = '0;
        p++;
      end else if (p + len <= k) begin
        case (len)
          1:       cp = {13'd0, seq[p]};
          2:       cp = {10'd0, seq[p][4:0], seq[p+1][5:0]};
          3:       cp = {5'd0, seq[p][3:0], seq[p+1][5:0], seq[p+2][5:0]};
          default: cp = {seq[p][2:0], seq[p+1][5:0], seq[p+2][5:0], seq[p+3][5:0]};
        endcase
        p += len;
      end else if (eot) begin
        cp = '0;
        p++;
      end else begin
        stop = 1'b1;
      end
      if (!stop) step_out.insert(step_out.size(), '{cp: cp, done: 1'b0});
    end
    held_n = 0;
    for (int i = p; i < k; i++) begin
      held[held_n] = seq[i];
      held_n++;
    end
    if (eot && step_out.size() > 0) step_out[step_out.size()-1].done = 1'b1;
  endtask

  // one byte across the input handshake, then its prediction
  task automatic drive_byte(input logic [7:0] data, input logic eot);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    utf8_decode_step(data, eot);
  endtask

  task automatic feed(input logic [7:0] data, input logic eot);
    drive_byte(data, eot);
    foreach (step_out[i]) cp_pending.insert(cp_pending.size(), step_out[i]);
    random_bytes++;
    if (random_bytes % 50 == 0) begin
      tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
    end
    if (random_bytes == 120) hold_cycles = HOLD_CYCLES;
  endtask

  // mostly well-formed sequences, some cut short, some raw noise
  task automatic feed_random_piece();
    int         kind;
    int         len;
    int         cut;
    logic [7:0] lead;
    logic       end_mark;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(1, 4);
    case (len)
      1:       lead = {1'b0, 7'($urandom)};
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    if (kind < 70) begin
      end_mark = ($urandom_range(0, 5) == 0);
      feed(lead, end_mark && len == 1);
      for (int i = 1; i < len; i++) feed({2'b10, 6'($urandom)}, end_mark && i == len - 1);
    end else if (kind < 85 && len > 1) begin
      cut = $urandom_range(1, len - 1);
      end_mark = ($urandom_range(0, 3) != 0);
      feed(lead, end_mark && cut == 1);
      for (int i = 1; i < cut; i++) feed({2'b10, 6'($urandom)}, end_mark && i == cut - 1);
    end else begin
      feed(8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  // sender
  initial begin
    logic [20:0] fix_cp [3];
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[r]) begin
      drive_byte(dir_rows[r].data, dir_rows[r].eot);
      if (dir_rows[r].n_fix == PREDICT) begin
        foreach (step_out[i]) cp_pending.insert(cp_pending.size(), step_out[i]);
      end else begin
        fix_cp = '{dir_rows[r].cp0, dir_rows[r].cp1, dir_rows[r].cp2};
        for (int i = 0; i < dir_rows[r].n_fix; i++)
          cp_pending.insert(cp_pending.size(), '{cp: fix_cp[i], done: dir_rows[r].done[i]});
      end
    end
    while (random_bytes < RANDOM_BYTES) feed_random_piece();
    s_tvalid <= 1'b0;
    while (cp_pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int stall;
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, rx_idle_max);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // compare each code point transfer with the oldest pending one
  always @(posedge clk) begin
    code_point_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (cp_pending.size() == 0) begin
        errors++;
        $display("%0t: expected no code point, got %h last %b", $time, m_tdata[20:0],
                 m_tlast);
      end else begin
        want = cp_pending.pop_front();
        if (m_tdata[20:0] !== want.cp) begin
          errors++;
          $display("%0t: code point expected %h, got %h", $time, want.cp, m_tdata[20:0]);
        end
        if (m_tlast !== want.done) begin
          errors++;
          $display("%0t: text done expected %b, got %b", $time, want.done, m_tlast);
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
